// ===== hdl/sphb_pkg.sv =====
// Shared types and constants for the space packet header builder.
package sphb_pkg;

  localparam int unsigned MaxBytes  = 11;
  localparam int unsigned ByteIdxW  = 4;
  localparam int unsigned ApidW     = 11;
  localparam int unsigned OptW      = 3;
  localparam int unsigned NameW     = 14;
  localparam int unsigned PfieldW   = 8;
  localparam int unsigned CfgDataW  = 14;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned LengthW   = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned SeqW      = 14;

  localparam logic [7:0]      SeqFlagsUnseg = 8'hC0;
  localparam logic [SeqW-1:0] SeqReset      = 14'd1;
  localparam logic [7:0]      SecHdrFlag    = 8'h08;

  localparam int unsigned OptPfieldBit    = 0;
  localparam int unsigned OptTimestampBit = 1;
  localparam int unsigned OptFixedNameBit = 2;

  localparam logic [ByteIdxW-1:0] LastIdxPlain  = 4'd5;
  localparam logic [ByteIdxW-1:0] LastIdxStamp  = 4'd9;
  localparam logic [ByteIdxW-1:0] LastIdxPfield = 4'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSourceApid    = 2'd0,
    CfgHeaderOptions = 2'd1,
    CfgPacketName    = 2'd2,
    CfgPfieldCode    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ApidW-1:0]   source_apid;
    logic [OptW-1:0]    header_options;
    logic [NameW-1:0]   packet_name;
    logic [PfieldW-1:0] pfield_code;
  } cfg_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] data;
    logic [ByteIdxW-1:0]      last_idx;
  } header_t;

endpackage

// ===== hdl/sphb_cfg_regs.sv =====
// Configuration register file for the space packet header builder.
module sphb_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [sphb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sphb_pkg::CfgDataW-1:0] cfg_wdata_i,
  output sphb_pkg::cfg_t           cfg_o
);
  import sphb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgSourceApid:    cfg_d.source_apid    = cfg_wdata_i[ApidW-1:0];
        CfgHeaderOptions: cfg_d.header_options = cfg_wdata_i[OptW-1:0];
        CfgPacketName:    cfg_d.packet_name    = cfg_wdata_i[NameW-1:0];
        CfgPfieldCode:    cfg_d.pfield_code    = cfg_wdata_i[PfieldW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/sphb_header_gen.sv =====
// Header byte assembly and packet sequence counter.
module sphb_header_gen (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sphb_pkg::cfg_t                 cfg_i,
  input  logic                           accept_i,
  input  logic [sphb_pkg::LengthW-1:0]   payload_length_i,
  input  logic [sphb_pkg::TimeW-1:0]     mission_time_i,
  output sphb_pkg::header_t              header_o
);
  import sphb_pkg::*;

  logic [SeqW-1:0]    seq_q, seq_d;
  logic               stamp, pfield;
  logic [2:0]         sec_len;
  logic [LengthW-1:0] len_field;
  logic [7:0]         b0;

  assign stamp     = cfg_i.header_options[OptTimestampBit];
  assign pfield    = stamp & cfg_i.header_options[OptPfieldBit];
  assign sec_len   = pfield ? 3'd5 : (stamp ? 3'd4 : 3'd0);
  assign len_field = payload_length_i + LengthW'(sec_len) - LengthW'(1);
  assign b0        = {5'd0, cfg_i.source_apid[ApidW-1:8]} | (stamp ? SecHdrFlag : 8'h00);
  assign seq_d     = seq_q + SeqW'(1);

  always_comb begin
    header_o.data    = '0;
    header_o.data[0] = b0;
    header_o.data[1] = cfg_i.source_apid[7:0];
    if (cfg_i.header_options[OptFixedNameBit]) begin
      header_o.data[2] = {2'b00, cfg_i.packet_name[NameW-1:8]};
      header_o.data[3] = cfg_i.packet_name[7:0];
    end else begin
      header_o.data[2] = {2'b00, seq_q[SeqW-1:8]} | SeqFlagsUnseg;
      header_o.data[3] = seq_q[7:0];
    end
    header_o.data[4] = len_field[15:8];
    header_o.data[5] = len_field[7:0];
    if (pfield) begin
      header_o.data[6]  = cfg_i.pfield_code;
      header_o.data[7]  = mission_time_i[31:24];
      header_o.data[8]  = mission_time_i[23:16];
      header_o.data[9]  = mission_time_i[15:8];
      header_o.data[10] = mission_time_i[7:0];
      header_o.last_idx = LastIdxPfield;
    end else if (stamp) begin
      header_o.data[6]  = mission_time_i[31:24];
      header_o.data[7]  = mission_time_i[23:16];
      header_o.data[8]  = mission_time_i[15:8];
      header_o.data[9]  = mission_time_i[7:0];
      header_o.last_idx = LastIdxStamp;
    end else begin
      header_o.last_idx = LastIdxPlain;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SeqReset;
    end else if (accept_i) begin
      seq_q <= seq_d;
    end
  end

endmodule

// ===== hdl/sphb_serializer.sv =====
// Frame register and byte-wide output register that stream the header out.
module sphb_serializer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sphb_pkg::header_t               header_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      header_byte_o,
  output logic [sphb_pkg::ByteIdxW-1:0]   byte_index_o,
  output logic                            last_byte_o
);
  import sphb_pkg::*;

  header_t             frame_q;
  logic                frame_valid_q;
  logic [ByteIdxW-1:0] idx_q;
  logic                out_valid_q;
  logic [7:0]          byte_q;
  logic [ByteIdxW-1:0] index_q;
  logic                last_q;
  logic                out_free, move, is_last, accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign move       = frame_valid_q && out_free;
  assign is_last    = (idx_q == frame_q.last_idx);
  assign in_ready_o = !frame_valid_q || (move && is_last);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
      idx_q         <= '0;
    end else if (accept) begin
      frame_valid_q <= 1'b1;
      idx_q         <= '0;
    end else if (move) begin
      idx_q <= idx_q + ByteIdxW'(1);
      if (is_last) begin
        frame_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q <= header_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      byte_q  <= frame_q.data[idx_q];
      index_q <= idx_q;
      last_q  <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign header_byte_o = byte_q;
  assign byte_index_o  = index_q;
  assign last_byte_o   = last_q;

endmodule

// ===== hdl/space_packet_header_builder_core.sv =====
// Top level of the space packet header builder.
//
// Each request transaction carries a payload length and the mission time and
// produces one header of 6, 10 or 11 bytes, one output transaction per byte,
// with last_byte_o set on the final one. The header is built from the
// configuration and the sequence count in the cycle the request is taken and
// held in a frame register, from which one byte a cycle moves into the output
// register while the output is not stalled. The next request is taken in
// the cycle the last byte of the current one leaves the frame register. The
// sequence count starts at 1 after reset and advances on every request. The
// user must write configuration only while idle; the block does not enforce it.
module space_packet_header_builder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sphb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sphb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sphb_pkg::LengthW-1:0]   payload_length_i,
  input  logic [sphb_pkg::TimeW-1:0]     mission_time_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     header_byte_o,
  output logic [sphb_pkg::ByteIdxW-1:0]  byte_index_o,
  output logic                           last_byte_o
);
  import sphb_pkg::*;

  cfg_t    cfg;
  header_t header;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  sphb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sphb_header_gen u_header_gen (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .accept_i         (accept),
    .payload_length_i (payload_length_i),
    .mission_time_i   (mission_time_i),
    .header_o         (header)
  );

  sphb_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .header_i      (header),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .header_byte_o (header_byte_o),
    .byte_index_o  (byte_index_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

// ===== sim/space_packet_header_builder_core_tb.sv =====
// Self-checking testbench for the space packet header builder core.
module space_packet_header_builder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sphb_pkg::*;

  typedef enum logic [1:0] {
    RxFree,
    RxCoin,
    RxEveryThird,
    RxTrickle
  } rx_mode_e;

  class header_checker;
    logic [ApidW-1:0]   apid;
    logic [OptW-1:0]    opts;
    logic [NameW-1:0]   name;
    logic [PfieldW-1:0] pcode;
    logic [SeqW-1:0]    seq_count;
    logic [7:0]         want_byte[$];
    logic [ByteIdxW-1:0] want_index[$];
    logic               want_last[$];
    int                 errors;

    function new();
      apid      = '0;
      opts      = '0;
      name      = '0;
      pcode     = '0;
      seq_count = SeqReset;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_e sel, logic [CfgDataW-1:0] data);
      case (sel)
        CfgSourceApid:    apid  = data[ApidW-1:0];
        CfgHeaderOptions: opts  = data[OptW-1:0];
        CfgPacketName:    name  = data[NameW-1:0];
        CfgPfieldCode:    pcode = data[PfieldW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return want_byte.size();
    endfunction

    function void note_request(logic [LengthW-1:0] plen, logic [TimeW-1:0] mtime);
      logic [7:0]         hdr[0:MaxBytes-1];
      logic [LengthW-1:0] sec_len;
      logic [LengthW-1:0] len_field;
      logic               stamp;
      logic               pf;
      int                 n;
      stamp = opts[OptTimestampBit];
      pf    = stamp && opts[OptPfieldBit];
      sec_len   = pf ? 16'd5 : (stamp ? 16'd4 : 16'd0);
      len_field = plen + sec_len - 16'd1;
      hdr[0] = {5'b00000, apid[10:8]} | (stamp ? SecHdrFlag : 8'h00);
      hdr[1] = apid[7:0];
      if (opts[OptFixedNameBit]) begin
        hdr[2] = {2'b00, name[13:8]};
        hdr[3] = name[7:0];
      end else begin
        hdr[2] = SeqFlagsUnseg | {2'b00, seq_count[13:8]};
        hdr[3] = seq_count[7:0];
      end
      seq_count = seq_count + 1'b1;
      hdr[4] = len_field[15:8];
      hdr[5] = len_field[7:0];
      n = 6;
      if (stamp) begin
        if (pf) begin
          hdr[n] = pcode;
          n++;
        end
        hdr[n]     = mtime[31:24];
        hdr[n + 1] = mtime[23:16];
        hdr[n + 2] = mtime[15:8];
        hdr[n + 3] = mtime[7:0];
        n += 4;
      end
      for (int i = 0; i < n; i++) begin
        want_byte.push_back(hdr[i]);
        want_index.push_back(ByteIdxW'(i));
        want_last.push_back(i == n - 1);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_byte(logic [7:0] got_byte, logic [ByteIdxW-1:0] got_index, logic got_last);
      logic [7:0]          exp_byte;
      logic [ByteIdxW-1:0] exp_index;
      logic                exp_last;
      if (want_byte.size() == 0) begin
        report($sformatf("unexpected byte %02h at index %0d", got_byte, got_index));
        return;
      end
      exp_byte  = want_byte.pop_front();
      exp_index = want_index.pop_front();
      exp_last  = want_last.pop_front();
      if (got_byte !== exp_byte) begin
        report($sformatf("header_byte %02h, expected %02h (index %0d)",
                         got_byte, exp_byte, exp_index));
      end
      if (got_index !== exp_index) begin
        report($sformatf("byte_index %0d, expected %0d", got_index, exp_index));
      end
      if (got_last !== exp_last) begin
        report($sformatf("last_byte %0b, expected %0b (index %0d)",
                         got_last, exp_last, exp_index));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [LengthW-1:0]  payload_length_i = '0;
  logic [TimeW-1:0]    mission_time_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          header_byte_o;
  logic [ByteIdxW-1:0] byte_index_o;
  logic                last_byte_o;

  header_checker book;
  int       burst_left = 0;
  rx_mode_e rx_mode = RxFree;
  int       rx_count = 0;
  int       rx_phase = 0;

  space_packet_header_builder_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .payload_length_i (payload_length_i),
    .mission_time_i   (mission_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .header_byte_o    (header_byte_o),
    .byte_index_o     (byte_index_o),
    .last_byte_o      (last_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      book.note_request(payload_length_i, mission_time_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      book.check_byte(header_byte_o, byte_index_o, last_byte_o);
    end
  end

  always @(negedge clk_i) begin
    if (rx_count == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 3));
      rx_count = $urandom_range(20, 80);
    end else begin
      rx_count--;
    end
    rx_phase++;
    case (rx_mode)
      RxFree:       out_ready_i <= 1'b1;
      RxCoin:       out_ready_i <= 1'($urandom_range(0, 1));
      RxEveryThird: out_ready_i <= (rx_phase % 3 == 0);
      default:      out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_reg(input cfg_reg_e sel, input logic [CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = sel;
    cfg_wdata_i = data;
    book.set_reg(sel, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_config(input logic [ApidW-1:0] apid, input logic [OptW-1:0] opts,
                            input logic [NameW-1:0] name, input logic [PfieldW-1:0] pcode);
    write_reg(CfgSourceApid, {3'($urandom), apid});
    write_reg(CfgHeaderOptions, {11'($urandom), opts});
    write_reg(CfgPacketName, name);
    write_reg(CfgPfieldCode, {6'($urandom), pcode});
  endtask

  task automatic send_request(input logic [LengthW-1:0] plen, input logic [TimeW-1:0] mtime);
    in_valid_i       = 1'b1;
    payload_length_i = plen;
    mission_time_i   = mtime;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [LengthW-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return LengthW'($urandom_range(65530, 65535));
      3:       return LengthW'($urandom_range(0, 15));
      default: return LengthW'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    book = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset configuration: the length field wraps on an empty payload.
    send_request(16'h0000, 32'h0000_0000);
    send_request(16'hFFFF, 32'hFFFF_FFFF);

    // A P-field option alone leaves the header at six bytes.
    wait_idle();
    set_config(11'h7FF, 3'b001, 14'h0000, 8'hFF);
    send_request(16'h0001, 32'h1234_5678);

    wait_idle();
    set_config(11'h7FF, 3'b010, 14'h3FFF, 8'hFF);
    send_request(16'h0000, 32'hFFFF_FFFF);
    send_request(16'hFFFF, 32'h0000_0000);

    wait_idle();
    set_config(11'h7FF, 3'b011, 14'h3FFF, 8'hFF);
    send_request(16'h0000, 32'h0000_0000);
    send_request(16'hFFFB, 32'hA5A5_5A5A);
    send_request(16'hFFFF, 32'hFFFF_FFFF);

    wait_idle();
    set_config(11'h555, 3'b100, 14'h3FFF, 8'h00);
    send_request(16'd100, 32'hDEAD_BEEF);

    wait_idle();
    set_config(11'h000, 3'b111, 14'h0000, 8'h00);
    send_request(16'h8000, 32'h8000_0001);
    send_request(16'h0003, 32'h7FFF_FFFE);

    wait_idle();
    set_config(11'h2AA, 3'b110, 14'h2AAA, 8'h5A);
    send_request(16'h1234, 32'h0102_0304);

    wait_idle();
    set_config(11'h3C3, 3'b101, 14'h1555, 8'hA5);
    send_request(16'h00FF, 32'hF0F0_0F0F);

    // Random phases, each header option setting once, register extremes in phases 0, 1, 6 and 7.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      set_config((p == 0) ? 11'h000 : (p == 7) ? 11'h7FF : 11'($urandom),
                 3'(p),
                 (p == 1) ? 14'h0000 : (p == 6) ? 14'h3FFF : 14'($urandom),
                 (p == 1) ? 8'h00 : (p == 6) ? 8'hFF : 8'($urandom));
      for (int k = 0; k < 25; k++) begin
        send_request(pick_length(), $urandom);
      end
    end
    in_valid_i = 1'b0;

    while (book.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
